// ===== design/des_key_schedule_assert.svh =====
// Assertion macros used by the key schedule RTL.
`ifndef DES_KEY_SCHEDULE_ASSERT_SVH
`define DES_KEY_SCHEDULE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DKS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DKS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dks_pkg.sv =====
// Types, tables and permutation functions for the DES key schedule.
package dks_pkg;

    localparam int unsigned C_ROUNDS = 16;
    localparam logic [3:0]  C_LAST_ROUND = 4'd15;

    typedef struct packed {
        logic        valid;
        logic [27:0] c;
        logic [27:0] d;
    } t_cell;

    localparam logic C_SHIFT_TWO [C_ROUNDS] = '{
        1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0
    };

    localparam logic [6:0] C_PC1 [56] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [6:0] C_PC2 [48] = '{
        7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,
        7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
        7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,
        7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
        7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55,
        7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
        7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53,
        7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
    };

    function automatic logic [55:0] f_pc1(input logic [63:0] key);
        logic [55:0] r;
        r = '0;
        for (int i = 0; i < 56; i++) begin
            r[55 - i] = key[6'(7'd64 - C_PC1[i])];
        end
        return r;
    endfunction

    function automatic logic [47:0] f_pc2(input logic [55:0] cd);
        logic [47:0] r;
        r = '0;
        for (int i = 0; i < 48; i++) begin
            r[47 - i] = cd[6'(7'd56 - C_PC2[i])];
        end
        return r;
    endfunction

endpackage

// ===== design/dks_cell.sv =====
// One round cell: rotates both key halves and hands them to the next cell.
module dks_cell
    import dks_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_two,
    input  t_cell i_prev,
    output t_cell o_cell
);

    logic        r_valid;
    logic [27:0] r_c;
    logic [27:0] r_d;
    logic [27:0] n_c;
    logic [27:0] n_d;

    always_comb begin
        if (i_two) begin
            n_c = {i_prev.c[25:0], i_prev.c[27:26]};
            n_d = {i_prev.d[25:0], i_prev.d[27:26]};
        end else begin
            n_c = {i_prev.c[26:0], i_prev.c[27]};
            n_d = {i_prev.d[26:0], i_prev.d[27]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c <= n_c;
            r_d <= n_d;
        end
    end

    assign o_cell = '{valid: r_valid, c: r_c, d: r_d};

endmodule

// ===== design/des_key_schedule.sv =====
// DES key schedule top level: PC-1, a row of sixteen round cells, PC-2 output stage.
//
//  channel  dir  handshake                   payload
//  s_axis   in   i_s_axis_tvalid/o_..tready  tdata[63:0] key
//  m_axis   out  o_m_axis_tvalid/i_..tready  tdata[47:0] subkey, tuser[3:0] round, tlast
//
// A key enters cell 0 and walks one cell per cycle while the output does not
// stall; cell k emits round k. The next key is taken in the cycle the
// sixteenth subkey leaves the last cell, so the row never holds two keys at once.
// Output stall freezes the whole row. Synchronous active-low reset empties
// all cells and the output register.
module des_key_schedule
    import dks_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [63:0] key
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [47:0] subkey
    output logic [3:0]  o_m_axis_tuser,   // [3:0] round
    output logic        o_m_axis_tlast
);

    t_cell       w_cell [C_ROUNDS];
    t_cell       w_head;
    logic [15:0] w_valid;
    logic        w_adv;
    logic        w_accept;
    logic [55:0] w_pc1;
    logic [27:0] w_sel_c;
    logic [27:0] w_sel_d;
    logic [3:0]  w_sel_round;

    logic        r_out_valid;
    logic [47:0] r_subkey;
    logic [3:0]  r_round;

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv && !(|w_valid[14:0]);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pc1           = f_pc1(i_s_axis_tdata);
    assign w_head          = '{valid: w_accept, c: w_pc1[55:28], d: w_pc1[27:0]};

    for (genvar k = 0; k < C_ROUNDS; k++) begin : g_cell
        dks_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_two   (C_SHIFT_TWO[k]),
            .i_prev  ((k == 0) ? w_head : w_cell[(k == 0) ? 0 : k - 1]),
            .o_cell  (w_cell[k])
        );
        assign w_valid[k] = w_cell[k].valid;
    end

    always_comb begin
        w_sel_c     = '0;
        w_sel_d     = '0;
        w_sel_round = '0;
        for (int k = 0; k < C_ROUNDS; k++) begin
            if (w_valid[k]) begin
                w_sel_c     = w_sel_c | w_cell[k].c;
                w_sel_d     = w_sel_d | w_cell[k].d;
                w_sel_round = w_sel_round | 4'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= |w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_subkey <= f_pc2({w_sel_c, w_sel_d});
            r_round  <= w_sel_round;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_subkey;
    assign o_m_axis_tuser  = r_round;
    assign o_m_axis_tlast  = (r_round == C_LAST_ROUND);

`include "des_key_schedule_assert.svh"

    `DKS_ASSERT_NOW(a_one_key_in_row, 1'b1, $onehot0(w_valid), "more than one cell holds a key")
    `DKS_ASSERT_NEXT(a_accept_fills_head, w_accept, w_valid[0], "accepted key missing in cell 0")
    `DKS_ASSERT_NEXT(a_tail_is_last, w_valid[15] && w_adv, o_m_axis_tvalid && o_m_axis_tlast, "tail cell did not give last subkey")

endmodule
